// ===== rtl/fwft_pkg.sv =====
// ============================================================================
// fwft_pkg
// Types and constants shared by the fixed-width field tokenizer modules.
// ============================================================================
package fwft_pkg;

    localparam int CFG_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = 6;
    localparam int CMDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_WHITESPACE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HAVE_HEADERS     = 2'd2;

    localparam logic [CFG_W-1:0] FIELD_WIDTH_RESET = 6'd10;

    localparam logic IN_DATA = 1'b0;
    localparam logic IN_EOS  = 1'b1;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_EOF  = 2'd1;
    localparam logic [1:0] KIND_EOR  = 2'd2;

    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0b;
    localparam logic [7:0] CH_FF  = 8'h0c;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_char;
        logic [7:0] column;
        logic       is_header;
        logic [7:0] field_count;
        logic [7:0] missing_columns;
        logic       last;
    } t_res;

    // one classified input: optional store write or flush, then char, eof, eor
    typedef struct packed {
        logic             hold;
        logic [CNT_W-1:0] cnt;
        logic             emit_char;
        logic [7:0]       ch;
        logic             emit_eof;
        logic             emit_eor;
        logic [7:0]       column;
        logic             hdr;
        logic [7:0]       eor_cnt;
        logic [7:0]       miss;
    } t_cmd;

endpackage

// ===== rtl/fwft_fifo.sv =====
// ============================================================================
// fwft_fifo
// Small first-in first-out queue with occupancy count.
// ============================================================================
module fwft_fifo #(
    parameter type t_data = logic,
    parameter int  DEPTH  = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  t_data                        i_data,
    input  logic                         i_pop,
    output t_data                        o_data,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    t_data           r_mem [DEPTH];
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_data  = r_mem[r_head];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (do_push) begin
            n_tail = (r_tail == AW'(DEPTH-1)) ? '0 : r_tail + AW'(1);
        end
        if (do_pop) begin
            n_head = (r_head == AW'(DEPTH-1)) ? '0 : r_head + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

endmodule

// ===== rtl/fwft_front.sv =====
// ============================================================================
// fwft_front
// Accepts input transactions, tracks line and field position and classifies
// each byte into a command for the back end.
// ============================================================================
module fwft_front #(
    parameter int         MAX_FIELD_WIDTH = 32,
    parameter logic [7:0] COL_LIMIT       = 8'd255
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [fwft_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [fwft_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                   i_accept,
    input  fwft_pkg::t_in                          i_in,
    output logic                                   o_cmd_push,
    output fwft_pkg::t_cmd                         o_cmd
);

    localparam logic [fwft_pkg::CNT_W-1:0] MAX_W = fwft_pkg::CNT_W'(MAX_FIELD_WIDTH);

    logic [fwft_pkg::CFG_W-1:0]  r_field_width;
    logic                        r_strip;
    logic                        r_have_headers;

    logic [fwft_pkg::CNT_W-1:0]  r_bif, n_bif;
    logic [7:0]                  r_fn, n_fn;
    logic                        r_lhb, n_lhb;
    logic                        r_ofl, n_ofl;
    logic                        r_cb, n_cb;
    logic [fwft_pkg::CNT_W-1:0]  r_hc, n_hc;
    logic [7:0]                  r_tc, n_tc;

    logic [fwft_pkg::CNT_W-1:0]  w;
    logic [fwft_pkg::CNT_W-1:0]  bif1;
    logic [fwft_pkg::CNT_W-1:0]  hc_e;
    logic                        cb_e;
    logic                        bif_zero;
    logic                        hdr;
    logic                        ws;
    logic [7:0]                  b;
    logic [7:0]                  fn_inc;
    logic [7:0]                  fn1;
    logic [7:0]                  miss;
    fwft_pkg::t_cmd              cmd;

    assign b        = i_in.data_byte;
    assign hdr      = r_have_headers & r_ofl;
    assign bif_zero = (r_bif == '0);
    assign cb_e     = bif_zero ? 1'b0 : r_cb;
    assign hc_e     = bif_zero ? '0 : r_hc;
    assign bif1     = r_bif + fwft_pkg::CNT_W'(1);
    assign fn_inc   = (r_fn < COL_LIMIT) ? r_fn + 8'd1 : r_fn;
    assign fn1      = bif_zero ? r_fn : fn_inc;
    assign miss     = r_ofl ? 8'd0 : ((r_tc > fn1) ? r_tc - fn1 : 8'd0);
    assign ws       = (b == fwft_pkg::CH_SP) || (b == fwft_pkg::CH_TAB) ||
                      (b == fwft_pkg::CH_VT) || (b == fwft_pkg::CH_FF);

    always_comb begin
        if (r_field_width == '0) begin
            w = fwft_pkg::CNT_W'(1);
        end else if (r_field_width > MAX_W) begin
            w = MAX_W;
        end else begin
            w = r_field_width;
        end
    end

    always_comb begin
        n_bif = r_bif;
        n_fn  = r_fn;
        n_lhb = r_lhb;
        n_ofl = r_ofl;
        n_cb  = r_cb;
        n_hc  = r_hc;
        n_tc  = r_tc;
        cmd        = '0;
        cmd.column = r_fn;
        cmd.hdr    = hdr;
        cmd.ch     = b;
        if (i_in.kind == fwft_pkg::IN_EOS || b == fwft_pkg::CH_LF ||
            b == fwft_pkg::CH_CR) begin
            if (i_in.kind == fwft_pkg::IN_DATA || r_lhb || !bif_zero) begin
                cmd.emit_eof = !bif_zero;
                cmd.emit_eor = 1'b1;
                cmd.eor_cnt  = fn1;
                cmd.miss     = miss;
                n_tc = r_ofl ? fn1 : r_tc;
            end
            n_fn  = '0;
            n_bif = '0;
            n_hc  = '0;
            n_cb  = 1'b0;
            n_lhb = 1'b0;
            n_ofl = 1'b0;
            if (i_in.kind == fwft_pkg::IN_EOS) begin
                n_ofl = 1'b1;
                n_tc  = '0;
            end
        end else begin
            n_lhb = 1'b1;
            if (r_strip && ws) begin
                n_cb = cb_e;
                n_hc = hc_e;
                if (cb_e && hc_e < MAX_W) begin
                    cmd.hold = 1'b1;
                    cmd.cnt  = hc_e;
                    n_hc     = hc_e + fwft_pkg::CNT_W'(1);
                end
            end else begin
                cmd.emit_char = 1'b1;
                cmd.cnt       = hc_e;
                n_hc          = '0;
                n_cb          = 1'b1;
            end
            if (bif1 >= w) begin
                cmd.emit_eof = 1'b1;
                n_fn  = fn_inc;
                n_bif = '0;
                n_hc  = '0;
                n_cb  = 1'b0;
            end else begin
                n_bif = bif1;
            end
        end
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = i_accept &&
                        (cmd.hold || cmd.emit_char || cmd.emit_eof || cmd.emit_eor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_width  <= fwft_pkg::FIELD_WIDTH_RESET;
            r_strip        <= 1'b0;
            r_have_headers <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fwft_pkg::CFG_FIELD_WIDTH:      r_field_width  <= i_cfg_data;
                fwft_pkg::CFG_STRIP_WHITESPACE: r_strip        <= i_cfg_data[0];
                fwft_pkg::CFG_HAVE_HEADERS:     r_have_headers <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bif <= '0;
            r_fn  <= '0;
            r_lhb <= 1'b0;
            r_ofl <= 1'b1;
            r_cb  <= 1'b0;
            r_hc  <= '0;
            r_tc  <= '0;
        end else if (i_accept) begin
            r_bif <= n_bif;
            r_fn  <= n_fn;
            r_lhb <= n_lhb;
            r_ofl <= n_ofl;
            r_cb  <= n_cb;
            r_hc  <= n_hc;
            r_tc  <= n_tc;
        end
    end

endmodule

// ===== rtl/fwft_back.sv =====
// ============================================================================
// fwft_back
// Carries out commands: keeps the held whitespace store and sequences the
// result transactions of each command into the output queue.
// ============================================================================
module fwft_back #(
    parameter int MAX_FIELD_WIDTH = 32,
    parameter int OUT_DEPTH       = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fwft_pkg::t_cmd                      i_cmd,
    input  logic                                i_cmd_empty,
    output logic                                o_cmd_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]      i_out_count,
    output logic                                o_res_push,
    output fwft_pkg::t_res                      o_res
);

    localparam int AW = (MAX_FIELD_WIDTH > 1) ? $clog2(MAX_FIELD_WIDTH) : 1;
    localparam int CW = $clog2(OUT_DEPTH+1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FLUSH = 3'd1;
    localparam logic [2:0] S_CHAR  = 3'd2;
    localparam logic [2:0] S_EOF   = 3'd3;
    localparam logic [2:0] S_EOR   = 3'd4;

    logic [7:0]                  r_store [MAX_FIELD_WIDTH];
    logic [2:0]                  r_state, n_state;
    logic [fwft_pkg::CNT_W-1:0]  r_idx, n_idx;
    fwft_pkg::t_cmd              r_cmd;
    logic                        r_pv;
    logic                        r_pmem;
    fwft_pkg::t_res              r_pres;
    logic [7:0]                  r_rd;

    logic [CW:0]                 fill;
    logic                        space;
    logic                        emit;
    logic                        step_last;
    logic                        done;
    logic                        pop;
    logic [2:0]                  first_state;
    fwft_pkg::t_res              res;

    assign fill  = (CW+1)'(i_out_count) + (CW+1)'(r_pv);
    assign space = fill < (CW+1)'(OUT_DEPTH);
    assign emit  = (r_state != S_IDLE) && space;
    assign done  = (r_state == S_IDLE) || (emit && step_last);
    assign pop   = done && !i_cmd_empty;
    assign o_cmd_pop = pop;

    always_comb begin
        if (i_cmd.emit_char && i_cmd.cnt != '0) begin
            first_state = S_FLUSH;
        end else if (i_cmd.emit_char) begin
            first_state = S_CHAR;
        end else if (i_cmd.emit_eof) begin
            first_state = S_EOF;
        end else if (i_cmd.emit_eor) begin
            first_state = S_EOR;
        end else begin
            first_state = S_IDLE;
        end
    end

    always_comb begin
        res           = '0;
        res.column    = r_cmd.column;
        res.is_header = r_cmd.hdr;
        step_last     = 1'b1;
        unique case (r_state)
            S_FLUSH: begin
                res.out_kind = fwft_pkg::KIND_CHAR;
                step_last    = 1'b0;
            end
            S_CHAR: begin
                res.out_kind = fwft_pkg::KIND_CHAR;
                res.out_char = r_cmd.ch;
                step_last    = !(r_cmd.emit_eof || r_cmd.emit_eor);
            end
            S_EOF: begin
                res.out_kind = fwft_pkg::KIND_EOF;
                step_last    = !r_cmd.emit_eor;
            end
            S_EOR: begin
                res.out_kind        = fwft_pkg::KIND_EOR;
                res.column          = '0;
                res.field_count     = r_cmd.eor_cnt;
                res.missing_columns = r_cmd.miss;
            end
            default: ;
        endcase
        res.last = step_last;
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        if (pop) begin
            n_state = first_state;
            n_idx   = '0;
        end else if (done) begin
            n_state = S_IDLE;
        end else if (emit) begin
            unique case (r_state)
                S_FLUSH: begin
                    n_idx = r_idx + fwft_pkg::CNT_W'(1);
                    if (r_idx + fwft_pkg::CNT_W'(1) == r_cmd.cnt) begin
                        n_state = S_CHAR;
                    end
                end
                S_CHAR:  n_state = r_cmd.emit_eof ? S_EOF : S_EOR;
                S_EOF:   n_state = S_EOR;
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pv    <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
        r_pres <= res;
        r_pmem <= (r_state == S_FLUSH);
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.hold) begin
            r_store[i_cmd.cnt[AW-1:0]] <= i_cmd.ch;
        end
        if (emit && r_state == S_FLUSH) begin
            r_rd <= r_store[r_idx[AW-1:0]];
        end
    end

    always_comb begin
        o_res = r_pres;
        if (r_pmem) begin
            o_res.out_char = r_rd;
        end
    end

    assign o_res_push = r_pv;

endmodule

// ===== rtl/fixed_width_field_tokenizer_core.sv =====
// ============================================================================
// fixed_width_field_tokenizer_core
// Splits a byte stream into lines and fixed-width fields with optional
// whitespace stripping and header row tracking.
// ============================================================================
// usage
//   input queue: drive i_in and push; a transaction is taken when full is low.
//   one data byte or end-of-stream marker per transaction.
//   result queue: o_res holds the oldest result while empty is low; pop takes it.
//   each input gives zero or more results; last marks the final one of an input.
//   configuration: i_cfg_we with i_cfg_index and i_cfg_data, written only when idle.
// result path
//   input to first result: command queue, sequencer, result register, result queue.
// throughput
//   back end sequencer moves one result per cycle while the result queue has room,
//   or one store write per cycle for held whitespace; an input with nothing to
//   emit or hold pushes no command.
//   front end takes one input per cycle while the four-entry command queue has room.
// reset
//   synchronous active low; queues empty, config back to defaults, first line next.
// stall
//   a held pop backs up the four-entry result queue, then the sequencer, then
//   the command queue, and finally full rises.
// ============================================================================
module fixed_width_field_tokenizer_core #(
    parameter int MAX_FIELD_WIDTH = 32,
    parameter int MAX_COLUMNS     = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fwft_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fwft_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  fwft_pkg::t_in                      i_in,
    output logic                               empty,
    input  logic                               pop,
    output fwft_pkg::t_res                     o_res
);

    localparam int COL_LIMIT_I = (MAX_COLUMNS - 1 < 255) ? MAX_COLUMNS - 1 : 255;
    localparam int OCW         = $clog2(fwft_pkg::OUTQ_DEPTH + 1);
    localparam int CCW         = $clog2(fwft_pkg::CMDQ_DEPTH + 1);

    logic            accept;
    logic            cmd_push;
    fwft_pkg::t_cmd  cmd_in;
    fwft_pkg::t_cmd  cmd_out;
    logic            cmd_empty;
    logic            cmd_pop;
    logic [CCW-1:0]  cmd_count;
    logic            res_push;
    fwft_pkg::t_res  res_in;
    logic [OCW-1:0]  out_count;
    logic            out_full;

    assign accept = push && !full;

    fwft_front #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH),
        .COL_LIMIT       (8'(COL_LIMIT_I))
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_in        (i_in),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    fwft_fifo #(
        .t_data (fwft_pkg::t_cmd),
        .DEPTH  (fwft_pkg::CMDQ_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty),
        .o_full  (full),
        .o_count (cmd_count)
    );

    fwft_back #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH),
        .OUT_DEPTH       (fwft_pkg::OUTQ_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty || (cmd_count == '0)),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    fwft_fifo #(
        .t_data (fwft_pkg::t_res),
        .DEPTH  (fwft_pkg::OUTQ_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push && !out_full),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (o_res),
        .o_empty (empty),
        .o_full  (out_full),
        .o_count (out_count)
    );

endmodule

// ===== rtl/fwft_checker.sv =====
// ============================================================================
// fwft_checker
// Port-level checks for the tokenizer core, attached by bind.
// ============================================================================
module fwft_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            full,
    input  logic            empty,
    input  logic            pop,
    input  fwft_pkg::t_res  o_res
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input queue full after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res)))
        else $error("stalled result changed");

    a_eor_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.out_kind == fwft_pkg::KIND_EOR) |->
        (o_res.column == 8'd0 && o_res.last && o_res.out_char == 8'd0))
        else $error("end of row result malformed");

    a_field_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.out_kind != fwft_pkg::KIND_EOR) |->
        (o_res.field_count == 8'd0 && o_res.missing_columns == 8'd0))
        else $error("row counts on a field result");

endmodule

bind fixed_width_field_tokenizer_core fwft_checker u_checker (.*);
